>>> src/hex_spiral_index_to_axial_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hexagonal spiral converter
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef HEX_SPIRAL_INDEX_TO_AXIAL_ASSERT_SVH
`define HEX_SPIRAL_INDEX_TO_AXIAL_ASSERT_SVH

`ifndef SYNTHESIS
`define HSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsi assertion failed");
`define HSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsi assertion failed");
`else
`define HSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/hsi_pkg.sv
// ----------------------------------------------------------------------------
// hsi_pkg
// Widths, constants, types and direction helpers of the spiral converter.
// ----------------------------------------------------------------------------
package hsi_pkg;

    localparam int IDX_W       = 18;
    localparam int COORD_W     = 9;
    localparam int RING_W      = 8;
    localparam int SEC_W       = 3;
    localparam int STEP_W      = 8;
    localparam int ROOT_W      = 9;
    localparam int RING_FULL_W = ROOT_W + 1;
    localparam int WIDE_W      = 21;
    localparam int TERM_W      = RING_FULL_W + 2;
    localparam int BIT_W       = 4;
    localparam int QUOT_W      = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int DEF_MAX_RING = 255;
    localparam logic [SEC_W-1:0] LAST_SECTOR = 3'd5;

    typedef struct packed {
        logic              ge;
        logic [WIDE_W-1:0] diff;
    } t_cmp_res;

    function automatic logic signed [1:0] dir_x(input logic [SEC_W-1:0] sec);
        logic signed [1:0] d;
        case (sec)
            3'd0, 3'd5: d = 2'sb01;
            3'd2, 3'd3: d = 2'sb11;
            default:    d = 2'sb00;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] dir_y(input logic [SEC_W-1:0] sec);
        logic signed [1:0] d;
        case (sec)
            3'd1, 3'd2: d = 2'sb01;
            3'd4, 3'd5: d = 2'sb11;
            default:    d = 2'sb00;
        endcase
        return d;
    endfunction

    function automatic logic [SEC_W-1:0] sec_plus2(input logic [SEC_W-1:0] sec);
        logic [SEC_W-1:0] s;
        case (sec)
            3'd4:    s = 3'd0;
            3'd5:    s = 3'd1;
            default: s = sec + 3'd2;
        endcase
        return s;
    endfunction

    function automatic logic signed [TERM_W-1:0] scale(
        input logic signed [1:0]      d,
        input logic [RING_FULL_W-1:0] v
    );
        logic signed [TERM_W-1:0] t;
        t = $signed({2'b00, v});
        case (d)
            2'sb01:  return t;
            2'sb11:  return -t;
            default: return '0;
        endcase
    endfunction

endpackage

>>> src/hsi_ringend.sv
// ----------------------------------------------------------------------------
// hsi_ringend
// First spiral index past ring t, 3t(t+1)+1, with one multiplier.
// ----------------------------------------------------------------------------
module hsi_ringend (
    input  logic [hsi_pkg::ROOT_W-1:0] i_root,
    output logic [hsi_pkg::WIDE_W-1:0] o_end
);

    logic [2*hsi_pkg::ROOT_W:0] prod;

    assign prod  = i_root * ({1'b0, i_root} + 10'd1);
    assign o_end = (hsi_pkg::WIDE_W'(prod) << 1) + hsi_pkg::WIDE_W'(prod)
                   + hsi_pkg::WIDE_W'(1);

endmodule

>>> src/hsi_cmpsub.sv
// ----------------------------------------------------------------------------
// hsi_cmpsub
// Shared compare and subtract unit used by the ring search, the offset subtraction and the division.
// ----------------------------------------------------------------------------
module hsi_cmpsub (
    input  logic [hsi_pkg::WIDE_W-1:0] i_a,
    input  logic [hsi_pkg::WIDE_W-1:0] i_b,
    output hsi_pkg::t_cmp_res          o_res
);

    logic [hsi_pkg::WIDE_W:0] full;

    assign full       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~full[hsi_pkg::WIDE_W];
    assign o_res.diff = full[hsi_pkg::WIDE_W-1:0];

endmodule

>>> src/hex_spiral_index_to_axial.sv
// ----------------------------------------------------------------------------
// hex_spiral_index_to_axial
// Converts a hexagonal spiral tile index to axial coordinates and ring data.
// ----------------------------------------------------------------------------
// The input stream carries one spiral index per beat in tdata bits 17:0.
// The output stream returns one beat per input: tdata holds coord_x,
// coord_y, ring, sector and step from the lowest bit up, and tuser bit 0
// flags an index past ring MAX_RING, with all tdata fields zero.
// The ring is found one root bit at a time, each bit taking a multiply
// state and a compare state; the offset in the ring is then divided by
// the ring with a three-step restoring division on the same subtractor.
// A regular index passes the root search, the offset subtraction, the division
// and the coordinate state; index zero and indices past the last ring skip them.
// Input ready returns with the edge that loads the output register, so no new
// index is taken while one is in progress; the serial root search sets the rate.
// Synchronous reset clears the sequencer and the output valid.
// A stalled receiver holds the result in the output register; the next
// index can be taken and worked on meanwhile, and waits at the end until
// the output register is free.
// ----------------------------------------------------------------------------
`include "hex_spiral_index_to_axial_assert.svh"

module hex_spiral_index_to_axial #(
    parameter int MAX_RING = hsi_pkg::DEF_MAX_RING
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // spiral_index[17:0], zero fill [23:18]
    input  logic [hsi_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // coord_x[8:0], coord_y[17:9], ring[25:18], sector[28:26], step[36:29],
    // zero fill [39:37]
    output logic [hsi_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // out_of_range[0]
    output logic [0:0]                         o_m_axis_tuser
);

    localparam longint unsigned RANGE_END =
        64'(3) * 64'(MAX_RING) * 64'(MAX_RING + 1) + 64'(1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_CMP, ST_SUB, ST_DIV, ST_CRD, ST_OUT
    } t_state;

    t_state                             r_state, n_state;
    logic [hsi_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic [hsi_pkg::ROOT_W-1:0]         r_root, n_root;
    logic [hsi_pkg::BIT_W-1:0]          r_bit, n_bit;
    logic [hsi_pkg::WIDE_W-1:0]         r_prod, n_prod;
    logic [hsi_pkg::WIDE_W-1:0]         r_base, n_base;
    logic [hsi_pkg::WIDE_W-1:0]         r_rem, n_rem;
    logic [hsi_pkg::RING_FULL_W-1:0]    r_ring, n_ring;
    logic [hsi_pkg::QUOT_W-1:0]         r_quot, n_quot;
    logic [hsi_pkg::OUT_TDATA_W-1:0]    r_res, n_res;
    logic                               r_res_oor, n_res_oor;
    logic                               r_out_valid, n_out_valid;
    logic [hsi_pkg::OUT_TDATA_W-1:0]    r_out_data, n_out_data;
    logic                               r_out_oor, n_out_oor;

    logic [hsi_pkg::ROOT_W-1:0]         cand;
    logic [hsi_pkg::WIDE_W-1:0]         cand_end;
    logic [hsi_pkg::WIDE_W-1:0]         unit_a, unit_b;
    hsi_pkg::t_cmp_res                  unit_res;
    logic [hsi_pkg::IDX_W-1:0]          in_idx;
    logic                               in_acc;
    logic [hsi_pkg::SEC_W-1:0]          sec;
    logic [hsi_pkg::SEC_W-1:0]          sec2;
    logic [hsi_pkg::RING_FULL_W-1:0]    stp;
    logic signed [hsi_pkg::TERM_W-1:0]  cx, cy;

    assign in_idx = i_s_axis_tdata[hsi_pkg::IDX_W-1:0];
    assign in_acc = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign cand   = r_root | (hsi_pkg::ROOT_W'(1) << r_bit);

    hsi_ringend u_ringend (
        .i_root (cand),
        .o_end  (cand_end)
    );

    always_comb begin
        unique case (r_state)
            ST_CMP: begin
                unit_a = hsi_pkg::WIDE_W'(r_idx);
                unit_b = r_prod;
            end
            ST_SUB: begin
                unit_a = hsi_pkg::WIDE_W'(r_idx);
                unit_b = r_base;
            end
            ST_DIV: begin
                unit_a = r_rem;
                unit_b = hsi_pkg::WIDE_W'(r_ring) << r_bit;
            end
            default: begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    hsi_cmpsub u_cmpsub (
        .i_a   (unit_a),
        .i_b   (unit_b),
        .o_res (unit_res)
    );

    assign sec  = (r_quot > hsi_pkg::LAST_SECTOR) ? hsi_pkg::LAST_SECTOR : r_quot;
    assign sec2 = hsi_pkg::sec_plus2(sec);
    assign stp  = r_rem[hsi_pkg::RING_FULL_W-1:0];
    assign cx   = hsi_pkg::scale(hsi_pkg::dir_x(sec), r_ring)
                + hsi_pkg::scale(hsi_pkg::dir_x(sec2), stp);
    assign cy   = hsi_pkg::scale(hsi_pkg::dir_y(sec), r_ring)
                + hsi_pkg::scale(hsi_pkg::dir_y(sec2), stp);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_root      = r_root;
        n_bit       = r_bit;
        n_prod      = r_prod;
        n_base      = r_base;
        n_rem       = r_rem;
        n_ring      = r_ring;
        n_quot      = r_quot;
        n_res       = r_res;
        n_res_oor   = r_res_oor;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_oor   = r_out_oor;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx  = in_idx;
                    n_root = '0;
                    n_bit  = hsi_pkg::BIT_W'(hsi_pkg::ROOT_W - 1);
                    n_base = hsi_pkg::WIDE_W'(1);
                    n_res  = '0;
                    if (in_idx == '0) begin
                        n_res_oor = 1'b0;
                        n_state   = ST_OUT;
                    end else if (64'(in_idx) >= RANGE_END) begin
                        n_res_oor = 1'b1;
                        n_state   = ST_OUT;
                    end else begin
                        n_res_oor = 1'b0;
                        n_state   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_prod  = cand_end;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (unit_res.ge) begin
                    n_root = cand;
                    n_base = r_prod;
                end
                if (r_bit == '0) begin
                    n_state = ST_SUB;
                end else begin
                    n_bit   = r_bit - hsi_pkg::BIT_W'(1);
                    n_state = ST_MUL;
                end
            end
            ST_SUB: begin
                n_rem   = unit_res.diff;
                n_ring  = {1'b0, r_root} + hsi_pkg::RING_FULL_W'(1);
                n_quot  = '0;
                n_bit   = hsi_pkg::BIT_W'(hsi_pkg::QUOT_W - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (unit_res.ge) begin
                    n_rem = unit_res.diff;
                    n_quot[r_bit[1:0]] = 1'b1;
                end
                if (r_bit == '0) begin
                    n_state = ST_CRD;
                end else begin
                    n_bit = r_bit - hsi_pkg::BIT_W'(1);
                end
            end
            ST_CRD: begin
                n_res = hsi_pkg::OUT_TDATA_W'({
                    stp[hsi_pkg::STEP_W-1:0],
                    sec,
                    r_ring[hsi_pkg::RING_W-1:0],
                    cy[hsi_pkg::COORD_W-1:0],
                    cx[hsi_pkg::COORD_W-1:0]
                });
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_out_oor   = r_res_oor;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_root     <= n_root;
        r_bit      <= n_bit;
        r_prod     <= n_prod;
        r_base     <= n_base;
        r_rem      <= n_rem;
        r_ring     <= n_ring;
        r_quot     <= n_quot;
        r_res      <= n_res;
        r_res_oor  <= n_res_oor;
        r_out_data <= n_out_data;
        r_out_oor  <= n_out_oor;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_oor;

    `HSI_ASSERT_IMPL(a_oor_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == '0)
    `HSI_ASSERT_IMPL(a_sector_max, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[28:26] <= hsi_pkg::LAST_SECTOR)
    `HSI_ASSERT_IMPL(a_base_below, i_clk, i_rst_n, r_state == ST_SUB, r_base <= hsi_pkg::WIDE_W'(r_idx))
    `HSI_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench of hex_spiral_index_to_axial
// Feeds spiral indices over the input stream and checks every result beat
// against a predictor that finds the ring, sector and step of the index and
// the axial coordinates of the tile. A short directed set covers the origin,
// ring and sector edges, the outermost ring, the last valid index and indices
// past it; random indices follow, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W        = hsi_pkg::IDX_W;
    localparam int COORD_W      = hsi_pkg::COORD_W;
    localparam int RING_W       = hsi_pkg::RING_W;
    localparam int SEC_W        = hsi_pkg::SEC_W;
    localparam int STEP_W       = hsi_pkg::STEP_W;
    localparam int IN_TDATA_W   = hsi_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W  = hsi_pkg::OUT_TDATA_W;
    localparam int DEF_MAX_RING = hsi_pkg::DEF_MAX_RING;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int STEP_X [6] = '{1, 0, -1, -1, 0, 1};
    localparam int STEP_Y [6] = '{0, 1, 1, 0, -1, -1};

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [RING_W-1:0]         ring;
        logic [SEC_W-1:0]          sector;
        logic [STEP_W-1:0]         step;
        logic                      out_of_range;
    } t_hex_tile;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // spiral_index[17:0], zero fill [23:18]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // coord_x[8:0], coord_y[17:9], ring[25:18], sector[28:26], step[36:29]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // out_of_range[0]
    logic [0:0]             m_axis_tuser;

    logic [IDX_W-1:0] indices_to_send [$];
    t_hex_tile        tiles_due [$];
    logic             idx_taken = 1'b0;
    logic             res_taken = 1'b0;
    logic             send_quiet = 1'b0;
    logic             recv_quiet = 1'b0;
    int unsigned      send_gap = 0;
    int unsigned      recv_stall = 0;
    int unsigned      cycles = 0;
    int unsigned      items_total = 0;
    int unsigned      results_seen = 0;
    bit               failed = 1'b0;

    hex_spiral_index_to_axial dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // First index past ring n.
    function automatic int unsigned ring_bound(input int unsigned n);
        return 3 * n * (n + 1) + 1;
    endfunction

    function automatic t_hex_tile locate_tile(input logic [IDX_W-1:0] index);
        t_hex_tile   t;
        int unsigned r;
        int unsigned offset;
        int unsigned sec;
        int unsigned pos;
        int unsigned turn;
        int          x;
        int          y;
        t = '0;
        if (index == '0) begin
            return t;
        end
        if (index >= ring_bound(DEF_MAX_RING)) begin
            t.out_of_range = 1'b1;
            return t;
        end
        r = 1;
        while (ring_bound(r) <= index) begin
            r++;
        end
        offset = index - ring_bound(r - 1);
        sec = offset / r;
        pos = offset % r;
        if (sec > 5) begin
            sec = 5;
        end
        turn = (sec + 2) % 6;
        x = STEP_X[sec] * int'(r) + STEP_X[turn] * int'(pos);
        y = STEP_Y[sec] * int'(r) + STEP_Y[turn] * int'(pos);
        t.coord_x = x[COORD_W-1:0];
        t.coord_y = y[COORD_W-1:0];
        t.ring    = r[RING_W-1:0];
        t.sector  = sec[SEC_W-1:0];
        t.step    = pos[STEP_W-1:0];
        return t;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned r;
        int unsigned v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, 127);
            2, 3: begin
                r = $urandom_range(1, DEF_MAX_RING);
                v = ring_bound(r - 1) + $urandom_range(0, 5) * r
                    + $urandom_range(0, 1) * (r - 1);
            end
            4: v = $urandom_range(ring_bound(DEF_MAX_RING), (1 << IDX_W) - 1);
            default: v = $urandom_range(0, ring_bound(DEF_MAX_RING) - 1);
        endcase
        return v[IDX_W-1:0];
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // Sender: a new beat once the previous one was taken and its gap ran out.
    always @(negedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_axis_tvalid || idx_taken) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (indices_to_send.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{(IN_TDATA_W - IDX_W){1'b0}}, indices_to_send.pop_front()};
                if ($urandom_range(0, 39) == 0) begin
                    send_quiet <= !send_quiet;
                end
                send_gap <= send_quiet ? 0 : $urandom_range(0, 12);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: after each result beat, ready drops for a random stall.
    always @(negedge clk) begin : receiver
        int unsigned w;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall <= 0;
        end else if (res_taken || !m_axis_tready) begin
            if (res_taken) begin
                if ($urandom_range(0, 39) == 0) begin
                    recv_quiet <= !recv_quiet;
                end
                w = recv_quiet ? 0 : $urandom_range(0, 12);
            end else begin
                w = recv_stall;
            end
            if (w == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                recv_stall <= w - 1;
            end
        end
    end

    always @(posedge clk) begin : watch
        t_hex_tile got;
        t_hex_tile want;
        if (!rst_n) begin
            idx_taken <= 1'b0;
            res_taken <= 1'b0;
        end else begin
            idx_taken <= s_axis_tvalid && s_axis_tready;
            res_taken <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                tiles_due.push_back(locate_tile(s_axis_tdata[IDX_W-1:0]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                got.coord_x      = m_axis_tdata[8:0];
                got.coord_y      = m_axis_tdata[17:9];
                got.ring         = m_axis_tdata[25:18];
                got.sector       = m_axis_tdata[28:26];
                got.step         = m_axis_tdata[36:29];
                got.out_of_range = m_axis_tuser[0];
                if (tiles_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    failed = 1'b1;
                end else begin
                    want = tiles_due.pop_front();
                    check_field("coord_x", want.coord_x, got.coord_x);
                    check_field("coord_y", want.coord_y, got.coord_y);
                    check_field("ring", want.ring, got.ring);
                    check_field("sector", want.sector, got.sector);
                    check_field("step", want.step, got.step);
                    check_field("out_of_range", want.out_of_range, got.out_of_range);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned outer;
        int unsigned k;
        outer = ring_bound(DEF_MAX_RING - 1);
        indices_to_send = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 18, 19, 37, 100};
        indices_to_send.push_back(IDX_W'(outer - 1));
        for (k = 0; k < 6; k++) begin
            indices_to_send.push_back(IDX_W'(outer + k * DEF_MAX_RING));
        end
        indices_to_send.push_back(IDX_W'(ring_bound(DEF_MAX_RING) - 1));
        indices_to_send.push_back(IDX_W'(ring_bound(DEF_MAX_RING)));
        indices_to_send.push_back({IDX_W{1'b1}});
        indices_to_send.push_back(IDX_W'(1 << (IDX_W - 1)));
        indices_to_send.push_back(IDX_W'((1 << (IDX_W - 2)) - 1));
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            indices_to_send.push_back(pick_index());
        end
        items_total = indices_to_send.size();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (results_seen < items_total) begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);

        if (tiles_due.size() != 0) begin
            $display("%0t: missing result beats, expected 0 pending, got %0d",
                     $time, tiles_due.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/hsi_pkg.sv
src/hsi_ringend.sv
src/hsi_cmpsub.sv
src/hex_spiral_index_to_axial.sv
bench/testbench.sv
